/* rtl/assert_macros.svh */
// Assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every clock edge outside reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
// Next-cycle implication checked outside reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

/* rtl/skj_pkg.sv */
// Skipjack package: F table, key byte select and round function
`default_nettype none
package skj_pkg;
	localparam int unsigned NumRounds = 32;

	typedef logic [7:0]  byte_t;
	typedef logic [15:0] word_t;
	typedef logic [79:0] key_t;

	typedef struct packed {
		logic  func;
		word_t w0;
		word_t w1;
		word_t w2;
		word_t w3;
	} state_t;

	localparam logic CfgKeyUpper = 1'b0;
	localparam logic CfgKeyLower = 1'b1;

	function automatic byte_t fbox(input byte_t x);
		byte_t r;
		case (x)
			8'h00: r=8'hA3; 8'h01: r=8'hD7; 8'h02: r=8'h09; 8'h03: r=8'h83;
			8'h04: r=8'hF8; 8'h05: r=8'h48; 8'h06: r=8'hF6; 8'h07: r=8'hF4;
			8'h08: r=8'hB3; 8'h09: r=8'h21; 8'h0A: r=8'h15; 8'h0B: r=8'h78;
			8'h0C: r=8'h99; 8'h0D: r=8'hB1; 8'h0E: r=8'hAF; 8'h0F: r=8'hF9;
			8'h10: r=8'hE7; 8'h11: r=8'h2D; 8'h12: r=8'h4D; 8'h13: r=8'h8A;
			8'h14: r=8'hCE; 8'h15: r=8'h4C; 8'h16: r=8'hCA; 8'h17: r=8'h2E;
			8'h18: r=8'h52; 8'h19: r=8'h95; 8'h1A: r=8'hD9; 8'h1B: r=8'h1E;
			8'h1C: r=8'h4E; 8'h1D: r=8'h38; 8'h1E: r=8'h44; 8'h1F: r=8'h28;
			8'h20: r=8'h0A; 8'h21: r=8'hDF; 8'h22: r=8'h02; 8'h23: r=8'hA0;
			8'h24: r=8'h17; 8'h25: r=8'hF1; 8'h26: r=8'h60; 8'h27: r=8'h68;
			8'h28: r=8'h12; 8'h29: r=8'hB7; 8'h2A: r=8'h7A; 8'h2B: r=8'hC3;
			8'h2C: r=8'hE9; 8'h2D: r=8'hFA; 8'h2E: r=8'h3D; 8'h2F: r=8'h53;
			8'h30: r=8'h96; 8'h31: r=8'h84; 8'h32: r=8'h6B; 8'h33: r=8'hBA;
			8'h34: r=8'hF2; 8'h35: r=8'h63; 8'h36: r=8'h9A; 8'h37: r=8'h19;
			8'h38: r=8'h7C; 8'h39: r=8'hAE; 8'h3A: r=8'hE5; 8'h3B: r=8'hF5;
			8'h3C: r=8'hF7; 8'h3D: r=8'h16; 8'h3E: r=8'h6A; 8'h3F: r=8'hA2;
			8'h40: r=8'h39; 8'h41: r=8'hB6; 8'h42: r=8'h7B; 8'h43: r=8'h0F;
			8'h44: r=8'hC1; 8'h45: r=8'h93; 8'h46: r=8'h81; 8'h47: r=8'h1B;
			8'h48: r=8'hEE; 8'h49: r=8'hB4; 8'h4A: r=8'h1A; 8'h4B: r=8'hEA;
			8'h4C: r=8'hD0; 8'h4D: r=8'h91; 8'h4E: r=8'h2F; 8'h4F: r=8'hB8;
			8'h50: r=8'h55; 8'h51: r=8'hB9; 8'h52: r=8'hDA; 8'h53: r=8'h85;
			8'h54: r=8'h3F; 8'h55: r=8'h41; 8'h56: r=8'hBF; 8'h57: r=8'hE0;
			8'h58: r=8'h5A; 8'h59: r=8'h58; 8'h5A: r=8'h80; 8'h5B: r=8'h5F;
			8'h5C: r=8'h66; 8'h5D: r=8'h0B; 8'h5E: r=8'hD8; 8'h5F: r=8'h90;
			8'h60: r=8'h35; 8'h61: r=8'hD5; 8'h62: r=8'hC0; 8'h63: r=8'hA7;
			8'h64: r=8'h33; 8'h65: r=8'h06; 8'h66: r=8'h65; 8'h67: r=8'h69;
			8'h68: r=8'h45; 8'h69: r=8'h00; 8'h6A: r=8'h94; 8'h6B: r=8'h56;
			8'h6C: r=8'h6D; 8'h6D: r=8'h98; 8'h6E: r=8'h9B; 8'h6F: r=8'h76;
			8'h70: r=8'h97; 8'h71: r=8'hFC; 8'h72: r=8'hB2; 8'h73: r=8'hC2;
			8'h74: r=8'hB0; 8'h75: r=8'hFE; 8'h76: r=8'hDB; 8'h77: r=8'h20;
			8'h78: r=8'hE1; 8'h79: r=8'hEB; 8'h7A: r=8'hD6; 8'h7B: r=8'hE4;
			8'h7C: r=8'hDD; 8'h7D: r=8'h47; 8'h7E: r=8'h4A; 8'h7F: r=8'h1D;
			8'h80: r=8'h42; 8'h81: r=8'hED; 8'h82: r=8'h9E; 8'h83: r=8'h6E;
			8'h84: r=8'h49; 8'h85: r=8'h3C; 8'h86: r=8'hCD; 8'h87: r=8'h43;
			8'h88: r=8'h27; 8'h89: r=8'hD2; 8'h8A: r=8'h07; 8'h8B: r=8'hD4;
			8'h8C: r=8'hDE; 8'h8D: r=8'hC7; 8'h8E: r=8'h67; 8'h8F: r=8'h18;
			8'h90: r=8'h89; 8'h91: r=8'hCB; 8'h92: r=8'h30; 8'h93: r=8'h1F;
			8'h94: r=8'h8D; 8'h95: r=8'hC6; 8'h96: r=8'h8F; 8'h97: r=8'hAA;
			8'h98: r=8'hC8; 8'h99: r=8'h74; 8'h9A: r=8'hDC; 8'h9B: r=8'hC9;
			8'h9C: r=8'h5D; 8'h9D: r=8'h5C; 8'h9E: r=8'h31; 8'h9F: r=8'hA4;
			8'hA0: r=8'h70; 8'hA1: r=8'h88; 8'hA2: r=8'h61; 8'hA3: r=8'h2C;
			8'hA4: r=8'h9F; 8'hA5: r=8'h0D; 8'hA6: r=8'h2B; 8'hA7: r=8'h87;
			8'hA8: r=8'h50; 8'hA9: r=8'h82; 8'hAA: r=8'h54; 8'hAB: r=8'h64;
			8'hAC: r=8'h26; 8'hAD: r=8'h7D; 8'hAE: r=8'h03; 8'hAF: r=8'h40;
			8'hB0: r=8'h34; 8'hB1: r=8'h4B; 8'hB2: r=8'h1C; 8'hB3: r=8'h73;
			8'hB4: r=8'hD1; 8'hB5: r=8'hC4; 8'hB6: r=8'hFD; 8'hB7: r=8'h3B;
			8'hB8: r=8'hCC; 8'hB9: r=8'hFB; 8'hBA: r=8'h7F; 8'hBB: r=8'hAB;
			8'hBC: r=8'hE6; 8'hBD: r=8'h3E; 8'hBE: r=8'h5B; 8'hBF: r=8'hA5;
			8'hC0: r=8'hAD; 8'hC1: r=8'h04; 8'hC2: r=8'h23; 8'hC3: r=8'h9C;
			8'hC4: r=8'h14; 8'hC5: r=8'h51; 8'hC6: r=8'h22; 8'hC7: r=8'hF0;
			8'hC8: r=8'h29; 8'hC9: r=8'h79; 8'hCA: r=8'h71; 8'hCB: r=8'h7E;
			8'hCC: r=8'hFF; 8'hCD: r=8'h8C; 8'hCE: r=8'h0E; 8'hCF: r=8'hE2;
			8'hD0: r=8'h0C; 8'hD1: r=8'hEF; 8'hD2: r=8'hBC; 8'hD3: r=8'h72;
			8'hD4: r=8'h75; 8'hD5: r=8'h6F; 8'hD6: r=8'h37; 8'hD7: r=8'hA1;
			8'hD8: r=8'hEC; 8'hD9: r=8'hD3; 8'hDA: r=8'h8E; 8'hDB: r=8'h62;
			8'hDC: r=8'h8B; 8'hDD: r=8'h86; 8'hDE: r=8'h10; 8'hDF: r=8'hE8;
			8'hE0: r=8'h08; 8'hE1: r=8'h77; 8'hE2: r=8'h11; 8'hE3: r=8'hBE;
			8'hE4: r=8'h92; 8'hE5: r=8'h4F; 8'hE6: r=8'h24; 8'hE7: r=8'hC5;
			8'hE8: r=8'h32; 8'hE9: r=8'h36; 8'hEA: r=8'h9D; 8'hEB: r=8'hCF;
			8'hEC: r=8'hF3; 8'hED: r=8'hA6; 8'hEE: r=8'hBB; 8'hEF: r=8'hAC;
			8'hF0: r=8'h5E; 8'hF1: r=8'h6C; 8'hF2: r=8'hA9; 8'hF3: r=8'h13;
			8'hF4: r=8'h57; 8'hF5: r=8'h25; 8'hF6: r=8'hB5; 8'hF7: r=8'hE3;
			8'hF8: r=8'hBD; 8'hF9: r=8'hA8; 8'hFA: r=8'h3A; 8'hFB: r=8'h01;
			8'hFC: r=8'h05; 8'hFD: r=8'h59; 8'hFE: r=8'h2A; default: r=8'h46;
		endcase
		return r;
	endfunction

	// Key byte n of the 80-bit key, byte 0 in the top bits
	function automatic byte_t keybyte(input key_t k, input int unsigned n);
		return k[8*(9-n) +: 8];
	endfunction

	// One round, encrypt or decrypt, round number rnd fixed per stage
	function automatic state_t round_f(input state_t s, input key_t k,
			input int unsigned rnd);
		int unsigned base;
		byte_t a;
		byte_t b;
		word_t ctr;
		state_t o;
		base = (rnd * 4) % 10;
		ctr  = 16'(rnd + 1);
		o    = s;
		if (!s.func) begin
			a = s.w0[15:8];
			b = s.w0[7:0];
			a ^= fbox(b ^ keybyte(k, base % 10));
			b ^= fbox(a ^ keybyte(k, (base + 1) % 10));
			a ^= fbox(b ^ keybyte(k, (base + 2) % 10));
			b ^= fbox(a ^ keybyte(k, (base + 3) % 10));
			if (((rnd >> 3) & 1) == 0) begin
				o.w0 = {a, b} ^ s.w3 ^ ctr;
				o.w1 = {a, b};
				o.w2 = s.w1;
				o.w3 = s.w2;
			end else begin
				o.w0 = s.w3;
				o.w1 = {a, b};
				o.w2 = s.w0 ^ s.w1 ^ ctr;
				o.w3 = s.w2;
			end
		end else begin
			a = s.w1[15:8];
			b = s.w1[7:0];
			b ^= fbox(a ^ keybyte(k, (base + 3) % 10));
			a ^= fbox(b ^ keybyte(k, (base + 2) % 10));
			b ^= fbox(a ^ keybyte(k, (base + 1) % 10));
			a ^= fbox(b ^ keybyte(k, base % 10));
			if (((rnd >> 3) & 1) == 0) begin
				o.w0 = {a, b};
				o.w1 = s.w2;
				o.w2 = s.w3;
				o.w3 = s.w0 ^ s.w1 ^ ctr;
			end else begin
				o.w0 = {a, b};
				o.w1 = {a, b} ^ s.w2 ^ ctr;
				o.w2 = s.w3;
				o.w3 = s.w0;
			end
		end
		return o;
	endfunction
endpackage
`default_nettype wire

/* rtl/skj_round_stage.sv */
// One pipeline stage: a single Skipjack round with valid and stall handling
`default_nettype none
module skj_round_stage import skj_pkg::*; #(
	parameter int unsigned Step = 0
) (
	input  wire     clk,
	input  wire     arst_n,
	input  wire     advance,
	input  wire     in_valid,
	input  state_t  in_state,
	input  key_t    key,
	output logic    out_valid,
	output state_t  out_state
);
	// Encrypt step k is round k, decrypt step k is round 31-k
	localparam int unsigned EncRnd = Step;
	localparam int unsigned DecRnd = NumRounds - 1 - Step;

	state_t enc_res;
	state_t dec_res;

	always_comb begin
		enc_res = round_f(in_state, key, EncRnd);
		dec_res = round_f(in_state, key, DecRnd);
	end

	// valid bit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (advance) begin
			out_valid <= in_valid;
		end
	end

	// data register
	always_ff @(posedge clk) begin
		if (advance) begin
			out_state <= in_state.func ? dec_res : enc_res;
		end
	end
endmodule
`default_nettype wire

/* rtl/skj_key_regs.sv */
// Key register file written over the configuration channel
`default_nettype none
module skj_key_regs import skj_pkg::*; (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         cfg_valid,
	input  wire  [0:0]  cfg_index,
	input  wire  [63:0] cfg_data,
	output key_t        key
);
	logic [15:0] key_upper_q;
	logic [63:0] key_lower_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_upper_q <= '0;
			key_lower_q <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index[0])
				CfgKeyUpper: key_upper_q <= cfg_data[15:0];
				CfgKeyLower: key_lower_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign key = {key_upper_q, key_lower_q};
endmodule
`default_nettype wire

/* rtl/skipjack_block_cipher_unit.sv */
// Top level of the pipelined Skipjack cipher unit
`default_nettype none
// Skipjack encrypt/decrypt, 64-bit block, 80-bit key. Thirty-two round
// stages, one round per register stage, take one block in every cycle
// unless stalled; the whole pipeline stalls when the output stage holds
// a result not taken. The key is written through the configuration
// channel (index 0: key bytes 0-1, index 1: key bytes 2-9; other indexes
// are ignored). Write it only while idle; the block does not enforce it.
module skipjack_block_cipher_unit import skj_pkg::*; (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         in_valid,
	output logic        in_ready,
	input  wire         func,
	input  wire  [63:0] block_in,
	output logic        out_valid,
	input  wire         out_ready,
	output logic [63:0] block_out,
	input  wire         cfg_valid,
	output logic        cfg_ready,
	input  wire  [63:0] cfg_index,
	input  wire  [63:0] cfg_data
);
	key_t   key;
	logic   advance;
	logic   vld [NumRounds+1];
	state_t st  [NumRounds+1];
	logic   cfg_hit;

	assign cfg_ready = 1'b1;
	assign cfg_hit   = cfg_valid && (cfg_index[63:1] == '0);

	skj_key_regs u_keys (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_valid(cfg_hit),
		.cfg_index(cfg_index[0:0]),
		.cfg_data (cfg_data),
		.key      (key)
	);

	// Stall everything while the last stage holds an untaken result
	assign advance  = !vld[NumRounds] || out_ready;
	assign in_ready = advance;

	assign vld[0] = in_valid;
	assign st[0]  = '{func: func, w0: block_in[63:48], w1: block_in[47:32],
		w2: block_in[31:16], w3: block_in[15:0]};

	for (genvar i = 0; i < NumRounds; i++) begin : g_rnd
		skj_round_stage #(.Step(i)) u_stage (
			.clk      (clk),
			.arst_n   (arst_n),
			.advance  (advance),
			.in_valid (vld[i]),
			.in_state (st[i]),
			.key      (key),
			.out_valid(vld[i+1]),
			.out_state(st[i+1])
		);
	end

	assign out_valid = vld[NumRounds];
	assign block_out = {st[NumRounds].w0, st[NumRounds].w1,
		st[NumRounds].w2, st[NumRounds].w3};
endmodule
`default_nettype wire

/* rtl/skj_checker.sv */
// Port-level checker for the Skipjack unit, bound to the top level
`default_nettype none
`include "assert_macros.svh"
module skj_checker (
	input wire        clk,
	input wire        arst_n,
	input wire        in_ready,
	input wire        out_valid,
	input wire        out_ready,
	input wire [63:0] block_out
);
	// Stalled result holds its data
	`ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(block_out), "result dropped or changed while stalled")
	// Input is ready whenever the output is empty
	`ASSERT_IMPL(a_ready_free, clk, arst_n, !out_valid, in_ready, "input blocked with empty output")
	// A stalled output stalls the input
	`ASSERT_IMPL(a_backpress, clk, arst_n, out_valid && !out_ready, !in_ready, "input taken while output stalled")
endmodule

bind skipjack_block_cipher_unit skj_checker u_skj_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.in_ready (in_ready),
	.out_valid(out_valid),
	.out_ready(out_ready),
	.block_out(block_out)
);
`default_nettype wire

/* tb/skipjack_block_cipher_unit_tb.sv */
// Self-checking testbench for the pipelined Skipjack cipher unit
`timescale 1ns / 100ps
`default_nettype none

module skipjack_block_cipher_unit_tb;
	import skj_pkg::*;

	localparam int unsigned CfgIdxUpper = 0;
	localparam int unsigned CfgIdxLower = 1;
	localparam int unsigned CfgIdxBad   = 7;
	localparam logic FuncEnc = 1'b0;
	localparam logic FuncDec = 1'b1;
	localparam int unsigned PipeDepth  = 32;
	localparam int unsigned CycleLimit = 400000;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic        func;
	logic [63:0] block_in;
	logic        out_valid;
	logic        out_ready;
	logic [63:0] block_out;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [63:0] cfg_index;
	logic [63:0] cfg_data;

	int unsigned cycle_cnt;
	int unsigned mismatch_cnt;
	bit          calm;      // no idling on either side
	bit          hold_out;  // long receiver hold-off

	// Independent table, written out here rather than borrowed
	byte unsigned ftab[256] = '{
		8'hA3,8'hD7,8'h09,8'h83,8'hF8,8'h48,8'hF6,8'hF4,8'hB3,8'h21,8'h15,8'h78,8'h99,8'hB1,
		8'hAF,8'hF9,8'hE7,8'h2D,8'h4D,8'h8A,8'hCE,8'h4C,8'hCA,8'h2E,8'h52,8'h95,8'hD9,8'h1E,
		8'h4E,8'h38,8'h44,8'h28,8'h0A,8'hDF,8'h02,8'hA0,8'h17,8'hF1,8'h60,8'h68,8'h12,8'hB7,
		8'h7A,8'hC3,8'hE9,8'hFA,8'h3D,8'h53,8'h96,8'h84,8'h6B,8'hBA,8'hF2,8'h63,8'h9A,8'h19,
		8'h7C,8'hAE,8'hE5,8'hF5,8'hF7,8'h16,8'h6A,8'hA2,8'h39,8'hB6,8'h7B,8'h0F,8'hC1,8'h93,
		8'h81,8'h1B,8'hEE,8'hB4,8'h1A,8'hEA,8'hD0,8'h91,8'h2F,8'hB8,8'h55,8'hB9,8'hDA,8'h85,
		8'h3F,8'h41,8'hBF,8'hE0,8'h5A,8'h58,8'h80,8'h5F,8'h66,8'h0B,8'hD8,8'h90,8'h35,8'hD5,
		8'hC0,8'hA7,8'h33,8'h06,8'h65,8'h69,8'h45,8'h00,8'h94,8'h56,8'h6D,8'h98,8'h9B,8'h76,
		8'h97,8'hFC,8'hB2,8'hC2,8'hB0,8'hFE,8'hDB,8'h20,8'hE1,8'hEB,8'hD6,8'hE4,8'hDD,8'h47,
		8'h4A,8'h1D,8'h42,8'hED,8'h9E,8'h6E,8'h49,8'h3C,8'hCD,8'h43,8'h27,8'hD2,8'h07,8'hD4,
		8'hDE,8'hC7,8'h67,8'h18,8'h89,8'hCB,8'h30,8'h1F,8'h8D,8'hC6,8'h8F,8'hAA,8'hC8,8'h74,
		8'hDC,8'hC9,8'h5D,8'h5C,8'h31,8'hA4,8'h70,8'h88,8'h61,8'h2C,8'h9F,8'h0D,8'h2B,8'h87,
		8'h50,8'h82,8'h54,8'h64,8'h26,8'h7D,8'h03,8'h40,8'h34,8'h4B,8'h1C,8'h73,8'hD1,8'hC4,
		8'hFD,8'h3B,8'hCC,8'hFB,8'h7F,8'hAB,8'hE6,8'h3E,8'h5B,8'hA5,8'hAD,8'h04,8'h23,8'h9C,
		8'h14,8'h51,8'h22,8'hF0,8'h29,8'h79,8'h71,8'h7E,8'hFF,8'h8C,8'h0E,8'hE2,8'h0C,8'hEF,
		8'hBC,8'h72,8'h75,8'h6F,8'h37,8'hA1,8'hEC,8'hD3,8'h8E,8'h62,8'h8B,8'h86,8'h10,8'hE8,
		8'h08,8'h77,8'h11,8'hBE,8'h92,8'h4F,8'h24,8'hC5,8'h32,8'h36,8'h9D,8'hCF,8'hF3,8'hA6,
		8'hBB,8'hAC,8'h5E,8'h6C,8'hA9,8'h13,8'h57,8'h25,8'hB5,8'hE3,8'hBD,8'hA8,8'h3A,8'h01,
		8'h05,8'h59,8'h2A,8'h46};

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		$display("mismatch %s: got %h, want %h", what, got, want);
		mismatch_cnt++;
	endtask

	// Predictor and store of expected cipher blocks
	class cipher_scoreboard;
		logic [15:0] key_hi;
		logic [63:0] key_lo;
		logic [63:0] pending[$];

		function new();
			key_hi = '0;
			key_lo = '0;
		endfunction

		function void write_key(input logic [63:0] idx, input logic [63:0] data);
			if (idx == CfgIdxUpper)
				key_hi = data[15:0];
			else if (idx == CfgIdxLower)
				key_lo = data;
		endfunction

		function byte_t kb(input int unsigned n);
			logic [79:0] k;
			k = {key_hi, key_lo};
			return k[79 - 8*n -: 8];
		endfunction

		function word_t g_fwd(input word_t w, input int unsigned r);
			int unsigned s;
			byte_t a, b;
			s = (r * 4) % 10;
			a = w[15:8];
			b = w[7:0];
			a ^= ftab[b ^ kb(s % 10)];
			b ^= ftab[a ^ kb((s + 1) % 10)];
			a ^= ftab[b ^ kb((s + 2) % 10)];
			b ^= ftab[a ^ kb((s + 3) % 10)];
			return {a, b};
		endfunction

		function word_t g_rev(input word_t w, input int unsigned r);
			int unsigned s;
			byte_t a, b;
			s = (r * 4) % 10;
			a = w[15:8];
			b = w[7:0];
			b ^= ftab[a ^ kb((s + 3) % 10)];
			a ^= ftab[b ^ kb((s + 2) % 10)];
			b ^= ftab[a ^ kb((s + 1) % 10)];
			a ^= ftab[b ^ kb(s % 10)];
			return {a, b};
		endfunction

		function logic [63:0] transform(input logic f, input logic [63:0] blk);
			word_t w0, w1, w2, w3, g, c, t;
			int unsigned r;
			{w0, w1, w2, w3} = blk;
			for (int k = 0; k < 32; k++) begin
				r = (f == FuncEnc) ? k : 31 - k;
				c = 16'(r + 1);
				if (f == FuncEnc) begin
					g = g_fwd(w0, r);
					if (r[3] == 1'b0) begin
						t = g ^ w3 ^ c;
						w3 = w2; w2 = w1; w1 = g; w0 = t;
					end else begin
						t = w0 ^ w1 ^ c;
						w0 = w3; w3 = w2; w2 = t; w1 = g;
					end
				end else begin
					g = g_rev(w1, r);
					if (r[3] == 1'b0) begin
						t = w0 ^ w1 ^ c;
						w0 = g; w1 = w2; w2 = w3; w3 = t;
					end else begin
						t = g ^ w2 ^ c;
						w1 = t; w2 = w3; w3 = w0; w0 = g;
					end
				end
			end
			return {w0, w1, w2, w3};
		endfunction

		function void note_input(input logic f, input logic [63:0] blk);
			pending.push_back(transform(f, blk));
		endfunction

		task check_result(input logic [63:0] got);
			logic [63:0] want;
			if (pending.size() == 0) begin
				report_mismatch("unexpected block_out", got, '0);
			end else begin
				want = pending.pop_front();
				if (got !== want)
					report_mismatch("block_out", got, want);
			end
		endtask
	endclass

	cipher_scoreboard sb;

	skipjack_block_cipher_unit i_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .func(func), .block_in(block_in),
		.out_valid(out_valid), .out_ready(out_ready), .block_out(block_out),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		clk = 1'b0; #10;
		clk = 1'b1; #10;
	end

	// Sample transfers at the rising edge
	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (arst_n && in_valid && in_ready)
			sb.note_input(func, block_in);
		if (arst_n && out_valid && out_ready)
			sb.check_result(block_out);
		if (cycle_cnt > CycleLimit) begin
			$display("timeout");
			$display("status: fail");
			$finish;
		end
	end

	// Receiver: random stalls unless calm, or a long hold-off on request
	always @(negedge clk) begin
		if (hold_out)
			out_ready <= 1'b0;
		else
			out_ready <= calm ? 1'b1 : ($urandom_range(99) >= 11);
	end

	task automatic write_cfg(input logic [63:0] idx, input logic [63:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		sb.write_key(idx, data);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Offer one block; valid stays high across back-to-back transfers
	task automatic send_block(input logic f, input logic [63:0] blk);
		@(negedge clk);
		if (!calm) begin
			while ($urandom_range(99) < 11) begin
				in_valid <= 1'b0;
				@(negedge clk);
			end
		end
		in_valid <= 1'b1;
		func     <= f;
		block_in <= blk;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic drain();
		@(negedge clk);
		in_valid <= 1'b0;
		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (PipeDepth + 4) @(posedge clk);
	endtask

	function automatic logic [63:0] rand64();
		return {$urandom(), $urandom()};
	endfunction

	task automatic random_blocks(input int n);
		for (int i = 0; i < n; i++)
			send_block(1'($urandom_range(1)), rand64());
	endtask

	// Long receiver hold-off while the sender keeps offering
	task automatic hold_receiver(input int cycles);
		hold_out = 1'b1;
		repeat (cycles) @(posedge clk);
		hold_out = 1'b0;
	endtask

	initial begin
		sb = new();
		arst_n = 1'b0;
		in_valid = 1'b0; func = 1'b0; block_in = '0;
		cfg_valid = 1'b0; cfg_index = '0; cfg_data = '0;
		out_ready = 1'b0;
		cycle_cnt = 0; mismatch_cnt = 0;
		calm = 1'b0; hold_out = 1'b0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: reset key, field extremes, both functions
		send_block(FuncEnc, '0);
		send_block(FuncDec, '0);
		send_block(FuncEnc, '1);
		send_block(FuncDec, '1);
		drain();
		// Key 00112233445566778899, plus an out-of-range index that must be ignored
		write_cfg(CfgIdxUpper, 64'hFFFF_FFFF_FFFF_0011);
		write_cfg(CfgIdxLower, 64'h2233_4455_6677_8899);
		write_cfg(CfgIdxBad, '1);
		send_block(FuncEnc, 64'h3322_1100_ddcc_bbaa);
		send_block(FuncDec, 64'h2587_cae2_7a12_d300);
		send_block(FuncEnc, 64'h8000_0000_0000_0001);
		send_block(FuncDec, 64'h5555_aaaa_5555_aaaa);
		drain();
		// All-ones key
		write_cfg(CfgIdxUpper, 64'hFFFF);
		write_cfg(CfgIdxLower, '1);
		send_block(FuncEnc, '0);
		send_block(FuncEnc, '1);
		send_block(FuncDec, '0);
		send_block(FuncDec, '1);
		drain();

		// Random phases under several keys, one with no idling and a hold-off
		for (int ph = 0; ph < 4; ph++) begin
			write_cfg(CfgIdxUpper, rand64());
			write_cfg(CfgIdxLower, rand64());
			if (ph == 2) begin
				calm = 1'b1;
				fork
					random_blocks(200);
					hold_receiver(150);
				join
				calm = 1'b0;
			end else begin
				random_blocks(200);
			end
			drain();
		end

		// Zero key again, the other extreme
		write_cfg(CfgIdxUpper, '0);
		write_cfg(CfgIdxLower, '0);
		random_blocks(20);
		drain();

		if (mismatch_cnt == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end
endmodule

`default_nettype wire

/* skipjack_block_cipher_unit.f */
+incdir+rtl
rtl/skj_pkg.sv
rtl/skj_round_stage.sv
rtl/skj_key_regs.sv
rtl/skipjack_block_cipher_unit.sv
rtl/skj_checker.sv
tb/skipjack_block_cipher_unit_tb.sv
